[rtl/core/olid_pkg.sv]
package olid_pkg;

    // Default list capacity
    localparam int DefCapacity = 16;

    // Field widths
    localparam int ValueW  = 32;
    localparam int CmdW    = 2;
    localparam int StatusW = 3;

    // Command codes
    localparam logic [CmdW-1:0] CmdInsert = 2'd0;
    localparam logic [CmdW-1:0] CmdDelete = 2'd1;
    localparam logic [CmdW-1:0] CmdList   = 2'd2;

    // Result status codes
    localparam logic [StatusW-1:0] StInserted = 3'd0;
    localparam logic [StatusW-1:0] StFull     = 3'd1;
    localparam logic [StatusW-1:0] StDeleted  = 3'd2;
    localparam logic [StatusW-1:0] StNotFound = 3'd3;
    localparam logic [StatusW-1:0] StEmpty    = 3'd4;
    localparam logic [StatusW-1:0] StListed   = 3'd5;

    // Controls broadcast from the sequencer to every cell
    typedef struct packed {
        logic load;   // write the new value into the selected cell
        logic shift;  // move every entry one cell toward the head
        logic wrap;   // during a shift, the selected cell takes the head value
    } cell_ctl_t;

endpackage

[rtl/core/olid_cell.sv]
module olid_cell #(
    parameter int IDX_W    = 4,
    parameter int CELL_IDX = 0
) (
    input  logic                        aclk,
    input  olid_pkg::cell_ctl_t         ctl,
    input  logic [IDX_W-1:0]            sel_idx,
    input  logic [olid_pkg::ValueW-1:0] wr_data,
    input  logic [olid_pkg::ValueW-1:0] head_data,
    input  logic [olid_pkg::ValueW-1:0] nbr_data,
    output logic [olid_pkg::ValueW-1:0] data
);
    import olid_pkg::*;

    localparam logic [IDX_W-1:0] MyIdx = IDX_W'(CELL_IDX);

    logic [ValueW-1:0] data_reg;
    logic [ValueW-1:0] data_next;
    logic              selected;

    assign selected = (sel_idx == MyIdx);

    // Load a new tail entry, or take the neighbor's entry on a shift;
    // the tail cell takes the head entry back when it is kept
    always_comb begin
        data_next = data_reg;
        if (ctl.load && selected) begin
            data_next = wr_data;
        end else if (ctl.shift) begin
            data_next = (ctl.wrap && selected) ? head_data : nbr_data;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

[rtl/core/ordered_list_insert_delete_core.sv]
// Channel | Ports                        | Contents
// --------+------------------------------+-------------------------------------------
// input   | s_tvalid s_tready s_tuser    | s_tuser: cmd[1:0]; s_tdata: value[31:0]
//         | s_tdata                      |
// result  | m_tvalid m_tready m_tuser    | m_tuser: status[2:0]; m_tdata: item[31:0];
//         | m_tdata m_tlast              | m_tlast: last result of the command
//
// Insert needs no walk. Delete and read out rotate the chain of cells once around
// the stored entries, one entry per cycle, so they take one step per stored entry (CAPACITY
// steps at most); read out also holds a rotation step while its result is not taken.
// A new command is taken only when the previous one is finished and the result
// register is free or being emptied. Reset empties the list; stored values are not cleared.
module ordered_list_insert_delete_core #(
    parameter int CAPACITY = olid_pkg::DefCapacity
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [olid_pkg::CmdW-1:0]           s_tuser,   // cmd[1:0]
    input  logic signed [olid_pkg::ValueW-1:0]  s_tdata,   // value[31:0]
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [olid_pkg::StatusW-1:0]        m_tuser,   // status[2:0]
    output logic signed [olid_pkg::ValueW-1:0]  m_tdata,   // item[31:0]
    output logic                                m_tlast
);
    import olid_pkg::*;

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam logic [CNT_W-1:0] CapCount = CNT_W'(CAPACITY);
    localparam logic [CNT_W-1:0] CntOne   = CNT_W'(1);

    localparam logic StIdle = 1'b0;
    localparam logic StWalk = 1'b1;

    // Control state
    logic              state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  left_reg, left_next;
    logic              del_reg, del_next;
    logic              found_reg, found_next;
    logic [ValueW-1:0] key_reg, key_next;

    // Result register
    logic               m_valid_reg, m_valid_next;
    logic [StatusW-1:0] m_status_reg, m_status_next;
    logic [ValueW-1:0]  m_item_reg, m_item_next;
    logic               m_last_reg, m_last_next;

    logic              out_free;
    logic              in_fire;
    logic              step;
    logic              drop;
    logic [CNT_W-1:0]  tail_cnt;
    logic [IDX_W-1:0]  sel_idx;
    cell_ctl_t         ctl;
    logic [ValueW-1:0] head;
    logic [ValueW-1:0] cell_q [CAPACITY];

    assign out_free = !m_valid_reg || m_tready;
    assign s_tready = (state_reg == StIdle) && out_free;
    assign in_fire  = s_tvalid && s_tready;

    // Delete steps every cycle; read out steps only when the result can move
    assign step = (state_reg == StWalk) && (del_reg || out_free);
    assign head = cell_q[0];
    assign drop = del_reg && !found_reg && (head == key_reg);

    // Select the tail cell while walking, the first free cell on insert
    assign tail_cnt = (state_reg == StWalk) ? (count_reg - CntOne) : count_reg;
    assign sel_idx  = tail_cnt[IDX_W-1:0];

    always_comb begin
        ctl.load  = in_fire && (s_tuser == CmdInsert) && (count_reg != CapCount);
        ctl.shift = step;
        ctl.wrap  = !drop;
    end

    // Chain of cells, head at index zero
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic [ValueW-1:0] nbr;
        if (i == CAPACITY - 1) begin : g_end
            assign nbr = cell_q[i];
        end else begin : g_mid
            assign nbr = cell_q[i+1];
        end
        olid_cell #(
            .IDX_W    (IDX_W),
            .CELL_IDX (i)
        ) u_cell (
            .aclk      (aclk),
            .ctl       (ctl),
            .sel_idx   (sel_idx),
            .wr_data   (s_tdata),
            .head_data (head),
            .nbr_data  (nbr),
            .data      (cell_q[i])
        );
    end

    // Sequence commands and fill the result register
    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        left_next     = left_reg;
        del_next      = del_reg;
        found_next    = found_reg;
        key_next      = key_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        m_status_next = m_status_reg;
        m_item_next   = m_item_reg;
        m_last_next   = m_last_reg;

        unique case (state_reg)
            StIdle: begin
                if (in_fire) begin
                    key_next   = s_tdata;
                    left_next  = count_reg;
                    found_next = 1'b0;
                    del_next   = (s_tuser == CmdDelete);
                    m_item_next = '0;
                    m_last_next = 1'b1;
                    unique case (s_tuser)
                        CmdInsert: begin
                            m_valid_next = 1'b1;
                            if (count_reg == CapCount) begin
                                m_status_next = StFull;
                            end else begin
                                m_status_next = StInserted;
                                count_next    = count_reg + CntOne;
                            end
                        end
                        CmdDelete, CmdList: begin
                            if (count_reg == '0) begin
                                m_valid_next  = 1'b1;
                                m_status_next = StEmpty;
                            end else begin
                                state_next = StWalk;
                            end
                        end
                        default: begin
                            // drop unused command codes
                        end
                    endcase
                end
            end
            StWalk: begin
                if (step) begin
                    left_next = left_reg - CntOne;
                    if (drop) begin
                        found_next = 1'b1;
                        count_next = count_reg - CntOne;
                    end
                    if (!del_reg) begin
                        m_valid_next  = 1'b1;
                        m_status_next = StListed;
                        m_item_next   = head;
                        m_last_next   = (left_reg == CntOne);
                    end
                    if (left_reg == CntOne) begin
                        state_next = StIdle;
                        if (del_reg) begin
                            m_valid_next  = 1'b1;
                            m_status_next = (found_reg || drop) ? StDeleted : StNotFound;
                            m_item_next   = '0;
                            m_last_next   = 1'b1;
                        end
                    end
                end
            end
            default: state_next = StIdle;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= StIdle;
            count_reg   <= '0;
            left_reg    <= '0;
            del_reg     <= 1'b0;
            found_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            left_reg    <= left_next;
            del_reg     <= del_next;
            found_reg   <= found_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        key_reg      <= key_next;
        m_status_reg <= m_status_next;
        m_item_reg   <= m_item_next;
        m_last_reg   <= m_last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_status_reg;
    assign m_tdata  = m_item_reg;
    assign m_tlast  = m_last_reg;

endmodule

[bench/ordered_list_insert_delete_core_test.sv]
`timescale 1ns / 1ps

module ordered_list_insert_delete_core_test;
    import olid_pkg::*;

    localparam int CAPACITY = DefCapacity;
    localparam logic [CmdW-1:0] CmdUnused = 2'd3;
    localparam int QuietLimit = 3000;
    localparam int HoldCycles = 400;
    localparam int TailCycles = 40;

    typedef struct packed {
        logic [StatusW-1:0] status;
        logic [ValueW-1:0]  item;
        logic               last;
    } result_t;

    typedef struct packed {
        logic [CmdW-1:0]    cmd;
        logic [ValueW-1:0]  value;
        logic               typed;
        logic [StatusW-1:0] status;
    } stim_row_t;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [CmdW-1:0]     s_tuser = CmdInsert;
    logic [ValueW-1:0]   s_tdata = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [StatusW-1:0]  m_tuser;
    logic [ValueW-1:0]   m_tdata;
    logic                m_tlast;

    // Side information that travels with each transaction on the input channel
    logic                row_typed = 1'b0;
    logic [StatusW-1:0]  row_status = StEmpty;

    logic [ValueW-1:0]   list_q[$];
    result_t             step_res[$];
    result_t             expect_q[$];
    int                  err_cnt = 0;
    int                  tx_idle_pct = 10;
    int                  rx_idle_pct = 53;
    int                  hold_reqs = 0;
    int                  hold_seen = 0;
    int                  hold_left = 0;
    int                  quiet = 0;
    bit                  filling = 1'b1;
    stim_row_t           directed[22];

    ordered_list_insert_delete_core #(
        .CAPACITY(CAPACITY)
    ) uut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tuser(s_tuser),
        .s_tdata(s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tuser(m_tuser),
        .m_tdata(m_tdata),
        .m_tlast(m_tlast)
    );

    always #10 aclk = ~aclk;

    // Apply one command to the list copy and collect the results it causes
    task automatic list_step(input logic [CmdW-1:0] cmd, input logic [ValueW-1:0] val);
        int hit;
        int n;
        hit = -1;
        n = list_q.size();
        step_res.delete();
        case (cmd)
            CmdInsert: begin
                if (n >= CAPACITY) begin
                    step_res.push_back('{StFull, '0, 1'b1});
                end else begin
                    list_q.push_back(val);
                    step_res.push_back('{StInserted, '0, 1'b1});
                end
            end
            CmdDelete: begin
                if (n == 0) begin
                    step_res.push_back('{StEmpty, '0, 1'b1});
                end else begin
                    for (int i = 0; i < n && hit < 0; i++) begin
                        if (list_q[i] == val) hit = i;
                    end
                    if (hit < 0) begin
                        step_res.push_back('{StNotFound, '0, 1'b1});
                    end else begin
                        list_q.delete(hit);
                        step_res.push_back('{StDeleted, '0, 1'b1});
                    end
                end
            end
            CmdList: begin
                if (n == 0) begin
                    step_res.push_back('{StEmpty, '0, 1'b1});
                end else begin
                    for (int i = 0; i < n; i++)
                        step_res.push_back('{StListed, list_q[i], i == n - 1});
                end
            end
            default: ;
        endcase
    endtask

    // Check result transactions, then record what each accepted command should produce
    always @(posedge aclk) begin : observe_blk
        result_t want;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (expect_q.size() == 0) begin
                    $error("unexpected result: status %0d item %h last %0d",
                           m_tuser, m_tdata, m_tlast);
                    err_cnt++;
                end else begin
                    want = expect_q.pop_front();
                    if (m_tuser !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, m_tuser);
                        err_cnt++;
                    end
                    if (m_tdata !== want.item) begin
                        $error("item: expected %h, got %h", want.item, m_tdata);
                        err_cnt++;
                    end
                    if (m_tlast !== want.last) begin
                        $error("last: expected %0d, got %0d", want.last, m_tlast);
                        err_cnt++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                list_step(s_tuser, s_tdata);
                if (row_typed) begin
                    expect_q.push_back('{row_status, '0, 1'b1});
                end else begin
                    foreach (step_res[i]) expect_q.push_back(step_res[i]);
                end
            end
        end
    end

    // Drive the result-side ready, with random idling and requested long holds
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left != 0) begin
            m_tready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_seen != hold_reqs) begin
            hold_seen <= hold_reqs;
            hold_left <= HoldCycles;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // End the run when no transaction moves for too long
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet <= 0;
        end else if (quiet == QuietLimit) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    // Offer one command and hold it until the block takes it
    task automatic send_cmd(input logic [CmdW-1:0] cmd, input logic [ValueW-1:0] val,
                            input logic typed, input logic [StatusW-1:0] status);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= cmd;
        s_tdata <= val;
        row_typed <= typed;
        row_status <= status;
        do @(posedge aclk); while (!s_tready);
    endtask

    function automatic logic [ValueW-1:0] pick_value();
        logic [ValueW-1:0] v;
        case ($urandom_range(9))
            0, 1, 2: v = $urandom_range(7) - 4;
            3: begin
                case ($urandom_range(3))
                    0: v = 32'h8000_0000;
                    1: v = 32'h7FFF_FFFF;
                    2: v = 32'h0000_0000;
                    default: v = 32'hFFFF_FFFF;
                endcase
            end
            default: v = $urandom;
        endcase
        return v;
    endfunction

    // Alternate between growing and shrinking the list; deletes mostly hit stored entries
    task automatic send_random();
        int pick;
        logic [CmdW-1:0] cmd;
        logic [ValueW-1:0] val;
        if (list_q.size() >= CAPACITY) filling = 1'b0;
        else if (list_q.size() == 0) filling = 1'b1;
        else if ($urandom_range(99) < 4) filling = !filling;
        pick = $urandom_range(99);
        if (pick < 4) cmd = CmdUnused;
        else if (pick < 16) cmd = CmdList;
        else if (pick < (filling ? 75 : 35)) cmd = CmdInsert;
        else cmd = CmdDelete;
        val = pick_value();
        if (cmd == CmdDelete && list_q.size() != 0 && $urandom_range(99) < 70)
            val = list_q[$urandom_range(list_q.size() - 1)];
        send_cmd(cmd, val, 1'b0, StEmpty);
    endtask

    // Stop offering and wait until every expected result has come out
    task automatic drain();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (expect_q.size() != 0);
    endtask

    initial begin
        directed = '{
            '{CmdList,   32'h0000_0000, 1'b1, StEmpty},
            '{CmdDelete, 32'h0000_0000, 1'b1, StEmpty},
            '{CmdUnused, 32'hFFFF_FFFF, 1'b0, StEmpty},
            '{CmdInsert, 32'h8000_0000, 1'b1, StInserted},
            '{CmdInsert, 32'h7FFF_FFFF, 1'b1, StInserted},
            '{CmdInsert, 32'h0000_0000, 1'b1, StInserted},
            '{CmdInsert, 32'hFFFF_FFFF, 1'b1, StInserted},
            '{CmdInsert, 32'h7FFF_FFFF, 1'b1, StInserted},
            '{CmdList,   32'h0000_0000, 1'b0, StEmpty},
            '{CmdDelete, 32'h0000_0005, 1'b1, StNotFound},
            // duplicate value: only the first copy goes
            '{CmdDelete, 32'h7FFF_FFFF, 1'b1, StDeleted},
            '{CmdList,   32'h5555_5555, 1'b0, StEmpty},
            '{CmdDelete, 32'h8000_0000, 1'b1, StDeleted},
            '{CmdDelete, 32'h7FFF_FFFF, 1'b1, StDeleted},
            '{CmdDelete, 32'h7FFF_FFFF, 1'b1, StNotFound},
            '{CmdList,   32'h0000_0000, 1'b0, StEmpty},
            '{CmdDelete, 32'h0000_0000, 1'b1, StDeleted},
            '{CmdDelete, 32'hFFFF_FFFF, 1'b1, StDeleted},
            '{CmdList,   32'h7FFF_FFFF, 1'b1, StEmpty},
            '{CmdInsert, 32'h1234_5678, 1'b1, StInserted},
            '{CmdList,   32'hAAAA_AAAA, 1'b0, StEmpty},
            '{CmdUnused, 32'h0000_0000, 1'b0, StEmpty}
        };

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed rows, then random traffic: sender idles lightly, receiver heavily
        foreach (directed[i])
            send_cmd(directed[i].cmd, directed[i].value, directed[i].typed, directed[i].status);
        repeat (45) send_random();
        drain();

        // Swap idling: sender idles heavily, receiver lightly
        tx_idle_pct = 53;
        rx_idle_pct = 10;
        repeat (40) send_random();

        // Hold the receiver for a long stretch while inserts pile up past capacity
        hold_reqs++;
        repeat (20) send_cmd(CmdInsert, pick_value(), 1'b0, StEmpty);
        send_cmd(CmdList, $urandom, 1'b0, StEmpty);

        // No idling on either side
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        repeat (42) send_random();

        drain();
        repeat (TailCycles) @(posedge aclk);
        if (err_cnt == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
